### sv/vsi_dq_power_current_controller_assert.svh
// Assertion macros for the dq power and current controller.
// Used by the top level; expects clk and rst_n in scope.
`ifndef VSI_DQ_POWER_CURRENT_CONTROLLER_ASSERT_SVH
`define VSI_DQ_POWER_CURRENT_CONTROLLER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define VDQ_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define VDQ_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/vdq_pkg.sv
// Package of the dq power and current controller: widths, register map,
// operation codes, sequencer states and the microprogram. No dependencies.
`timescale 1ns / 1ps
package vdq_pkg;

    localparam int DATA_W        = 64;
    localparam int FRAC_BITS_DEF = 32;
    localparam int ADDR_W        = 5;
    localparam int MEM_DEPTH     = 32;
    localparam int PC_W          = 7;
    localparam int CFG_IDX_W     = 3;

    localparam logic [DATA_W-1:0] H_RESET = 64'd429497;
    localparam logic [DATA_W-1:0] W_MASK  = {1'b0, {63{1'b1}}};
    localparam logic [DATA_W-1:0] H_MASK  = 64'h0000_0001_FFFF_FFFF;
    localparam logic [DATA_W-1:0] S_MAX   = {1'b0, {63{1'b1}}};
    localparam logic [DATA_W-1:0] S_MIN   = {1'b1, {63{1'b0}}};

    localparam logic [CFG_IDX_W-1:0] CFG_W = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_H = 3'd7;

    // register file map
    localparam logic [ADDR_W-1:0] A_PREF = 5'd0;
    localparam logic [ADDR_W-1:0] A_QREF = 5'd1;
    localparam logic [ADDR_W-1:0] A_KP   = 5'd2;
    localparam logic [ADDR_W-1:0] A_KI   = 5'd3;
    localparam logic [ADDR_W-1:0] A_KPC  = 5'd4;
    localparam logic [ADDR_W-1:0] A_KIC  = 5'd5;
    localparam logic [ADDR_W-1:0] A_W    = 5'd6;
    localparam logic [ADDR_W-1:0] A_H    = 5'd7;
    localparam logic [ADDR_W-1:0] A_PVD  = 5'd8;
    localparam logic [ADDR_W-1:0] A_PVQ  = 5'd9;
    localparam logic [ADDR_W-1:0] A_PID  = 5'd10;
    localparam logic [ADDR_W-1:0] A_PIQ  = 5'd11;
    localparam logic [ADDR_W-1:0] A_X0   = 5'd12;
    localparam logic [ADDR_W-1:0] A_X1   = 5'd13;
    localparam logic [ADDR_W-1:0] A_X2   = 5'd14;
    localparam logic [ADDR_W-1:0] A_X3   = 5'd15;
    localparam logic [ADDR_W-1:0] A_X4   = 5'd16;
    localparam logic [ADDR_W-1:0] A_X5   = 5'd17;
    localparam logic [ADDR_W-1:0] A_VD   = 5'd18;
    localparam logic [ADDR_W-1:0] A_VQ   = 5'd19;
    localparam logic [ADDR_W-1:0] A_ID   = 5'd20;
    localparam logic [ADDR_W-1:0] A_IQ   = 5'd21;
    localparam logic [ADDR_W-1:0] A_T0   = 5'd22;
    localparam logic [ADDR_W-1:0] A_T1   = 5'd23;
    localparam logic [ADDR_W-1:0] A_T2   = 5'd24;
    localparam logic [ADDR_W-1:0] A_T3   = 5'd25;
    localparam logic [ADDR_W-1:0] A_T4   = 5'd26;
    localparam logic [ADDR_W-1:0] A_T5   = 5'd27;
    localparam logic [ADDR_W-1:0] A_T6   = 5'd28;
    localparam logic [ADDR_W-1:0] A_T7   = 5'd29;
    localparam logic [ADDR_W-1:0] A_T8   = 5'd30;
    localparam logic [ADDR_W-1:0] A_T9   = 5'd31;

    // load selectors carried in the b field
    localparam logic [ADDR_W-1:0] LX_VD   = 5'd0;
    localparam logic [ADDR_W-1:0] LX_VQ   = 5'd1;
    localparam logic [ADDR_W-1:0] LX_ID   = 5'd2;
    localparam logic [ADDR_W-1:0] LX_IQ   = 5'd3;
    localparam logic [ADDR_W-1:0] LX_ONE  = 5'd4;
    localparam logic [ADDR_W-1:0] LX_ZERO = 5'd5;

    localparam logic [PC_W-1:0] PC_STEP = 7'd0;
    localparam logic [PC_W-1:0] PC_TAIL = 7'd67;
    localparam logic [PC_W-1:0] PC_INIT = 7'd87;

    typedef enum logic [2:0] {
        OP_MOV, OP_LDX, OP_ADD, OP_SUB, OP_MUL, OP_MULH, OP_DIV
    } op_t;

    typedef enum logic [1:0] {OSEL_NONE, OSEL_D, OSEL_Q} osel_t;

    typedef struct packed {
        op_t               op;
        logic [ADDR_W-1:0] dst;
        logic [ADDR_W-1:0] a;
        logic [ADDR_W-1:0] b;
        osel_t             osel;
        logic              last;
        logic              to_tail;
    } instr_t;

    typedef enum logic [3:0] {
        S_IDLE, S_FETCH, S_EXEC, S_MUL, S_MNEG, S_MFIN, S_DIV, S_DFIN, S_DONE
    } state_t;

    function automatic instr_t mk(op_t op, logic [ADDR_W-1:0] d,
                                  logic [ADDR_W-1:0] a, logic [ADDR_W-1:0] b);
        instr_t i;
        i.op      = op;
        i.dst     = d;
        i.a       = a;
        i.b       = b;
        i.osel    = OSEL_NONE;
        i.last    = 1'b0;
        i.to_tail = 1'b0;
        return i;
    endfunction

    // regular step at PC_STEP falls into the output tail; init jumps to it
    function automatic instr_t prog(logic [PC_W-1:0] pc);
        instr_t i;
        i = mk(OP_MOV, A_T9, A_T9, A_T9);
        case (pc)
            7'd0:  i = mk(OP_LDX, A_VD, A_VD, LX_VD);
            7'd1:  i = mk(OP_LDX, A_VQ, A_VQ, LX_VQ);
            7'd2:  i = mk(OP_LDX, A_ID, A_ID, LX_ID);
            7'd3:  i = mk(OP_LDX, A_IQ, A_IQ, LX_IQ);
            7'd4:  i = mk(OP_ADD, A_T0, A_PREF, A_PREF);
            7'd5:  i = mk(OP_ADD, A_T1, A_QREF, A_QREF);
            7'd6:  i = mk(OP_ADD, A_PVD, A_VD, A_PVD);
            7'd7:  i = mk(OP_ADD, A_PVQ, A_VQ, A_PVQ);
            7'd8:  i = mk(OP_ADD, A_PID, A_ID, A_PID);
            7'd9:  i = mk(OP_ADD, A_PIQ, A_IQ, A_PIQ);
            7'd10: i = mk(OP_MUL, A_T2, A_W, A_ID);
            7'd11: i = mk(OP_MUL, A_T3, A_W, A_IQ);
            7'd12: i = mk(OP_MULH, A_T4, A_H, A_W);
            7'd13: i = mk(OP_LDX, A_T5, A_T5, LX_ONE);
            7'd14: i = mk(OP_ADD, A_T4, A_T5, A_T4);
            7'd15: i = mk(OP_MUL, A_T5, A_T2, A_PVD);
            7'd16: i = mk(OP_MUL, A_T6, A_T3, A_PVQ);
            7'd17: i = mk(OP_ADD, A_T5, A_T5, A_T6);
            7'd18: i = mk(OP_MUL, A_T6, A_W, A_X0);
            7'd19: i = mk(OP_SUB, A_T5, A_T5, A_T6);
            7'd20: i = mk(OP_MULH, A_T5, A_H, A_T5);
            7'd21: i = mk(OP_ADD, A_T5, A_X0, A_T5);
            7'd22: i = mk(OP_MUL, A_T6, A_T2, A_PVQ);
            7'd23: i = mk(OP_MUL, A_T7, A_T3, A_PVD);
            7'd24: i = mk(OP_SUB, A_T6, A_T6, A_T7);
            7'd25: i = mk(OP_MUL, A_T7, A_W, A_X1);
            7'd26: i = mk(OP_SUB, A_T6, A_T6, A_T7);
            7'd27: i = mk(OP_MULH, A_T6, A_H, A_T6);
            7'd28: i = mk(OP_ADD, A_T6, A_X1, A_T6);
            7'd29: i = mk(OP_SUB, A_T2, A_T0, A_X0);
            7'd30: i = mk(OP_MULH, A_T2, A_H, A_T2);
            7'd31: i = mk(OP_ADD, A_T2, A_X2, A_T2);
            7'd32: i = mk(OP_SUB, A_T3, A_X1, A_T1);
            7'd33: i = mk(OP_MULH, A_T3, A_H, A_T3);
            7'd34: i = mk(OP_ADD, A_T3, A_X3, A_T3);
            7'd35: i = mk(OP_MUL, A_T7, A_KI, A_X2);
            7'd36: i = mk(OP_MUL, A_T8, A_KP, A_X0);
            7'd37: i = mk(OP_SUB, A_T7, A_T7, A_T8);
            7'd38: i = mk(OP_MUL, A_T8, A_KP, A_T0);
            7'd39: i = mk(OP_ADD, A_T7, A_T7, A_T8);
            7'd40: i = mk(OP_SUB, A_T7, A_T7, A_PID);
            7'd41: i = mk(OP_MULH, A_T7, A_H, A_T7);
            7'd42: i = mk(OP_ADD, A_T7, A_X4, A_T7);
            7'd43: i = mk(OP_MUL, A_T8, A_KP, A_X1);
            7'd44: i = mk(OP_MUL, A_T9, A_KI, A_X3);
            7'd45: i = mk(OP_ADD, A_T8, A_T8, A_T9);
            7'd46: i = mk(OP_MUL, A_T9, A_KP, A_T1);
            7'd47: i = mk(OP_SUB, A_T8, A_T8, A_T9);
            7'd48: i = mk(OP_SUB, A_T8, A_T8, A_PIQ);
            7'd49: i = mk(OP_MULH, A_T8, A_H, A_T8);
            7'd50: i = mk(OP_ADD, A_T8, A_X5, A_T8);
            7'd51: i = mk(OP_DIV, A_X0, A_T5, A_T4);
            7'd52: i = mk(OP_DIV, A_X1, A_T6, A_T4);
            7'd53: i = mk(OP_MULH, A_T9, A_H, A_X0);
            7'd54: i = mk(OP_SUB, A_X2, A_T2, A_T9);
            7'd55: i = mk(OP_MULH, A_T9, A_H, A_X1);
            7'd56: i = mk(OP_ADD, A_X3, A_T3, A_T9);
            7'd57: i = mk(OP_MUL, A_T9, A_KI, A_X2);
            7'd58: i = mk(OP_MUL, A_T0, A_KP, A_X0);
            7'd59: i = mk(OP_SUB, A_T9, A_T9, A_T0);
            7'd60: i = mk(OP_MULH, A_T9, A_H, A_T9);
            7'd61: i = mk(OP_ADD, A_X4, A_T7, A_T9);
            7'd62: i = mk(OP_MUL, A_T9, A_KP, A_X1);
            7'd63: i = mk(OP_MUL, A_T0, A_KI, A_X3);
            7'd64: i = mk(OP_ADD, A_T9, A_T9, A_T0);
            7'd65: i = mk(OP_MULH, A_T9, A_H, A_T9);
            7'd66: i = mk(OP_ADD, A_X5, A_T8, A_T9);
            7'd67: i = mk(OP_MOV, A_PVD, A_VD, A_VD);
            7'd68: i = mk(OP_MOV, A_PVQ, A_VQ, A_VQ);
            7'd69: i = mk(OP_MOV, A_PID, A_ID, A_ID);
            7'd70: i = mk(OP_MOV, A_PIQ, A_IQ, A_IQ);
            7'd71: i = mk(OP_SUB, A_T0, A_PREF, A_X0);
            7'd72: i = mk(OP_MUL, A_T0, A_KP, A_T0);
            7'd73: i = mk(OP_MUL, A_T1, A_KI, A_X2);
            7'd74: i = mk(OP_ADD, A_T0, A_T0, A_T1);
            7'd75: i = mk(OP_SUB, A_T0, A_T0, A_ID);
            7'd76: i = mk(OP_MUL, A_T0, A_KPC, A_T0);
            7'd77: i = mk(OP_MUL, A_T1, A_KIC, A_X4);
            7'd78:
            begin
                i = mk(OP_ADD, A_T0, A_T0, A_T1);
                i.osel = OSEL_D;
            end
            7'd79: i = mk(OP_SUB, A_T1, A_X1, A_QREF);
            7'd80: i = mk(OP_MUL, A_T1, A_KP, A_T1);
            7'd81: i = mk(OP_MUL, A_T2, A_KI, A_X3);
            7'd82: i = mk(OP_ADD, A_T1, A_T1, A_T2);
            7'd83: i = mk(OP_SUB, A_T1, A_T1, A_IQ);
            7'd84: i = mk(OP_MUL, A_T1, A_KPC, A_T1);
            7'd85: i = mk(OP_MUL, A_T2, A_KIC, A_X5);
            7'd86:
            begin
                i = mk(OP_ADD, A_T1, A_T1, A_T2);
                i.osel = OSEL_Q;
                i.last = 1'b1;
            end
            7'd87: i = mk(OP_LDX, A_VD, A_VD, LX_VD);
            7'd88: i = mk(OP_LDX, A_VQ, A_VQ, LX_VQ);
            7'd89: i = mk(OP_LDX, A_ID, A_ID, LX_ID);
            7'd90: i = mk(OP_LDX, A_IQ, A_IQ, LX_IQ);
            7'd91: i = mk(OP_LDX, A_T0, A_T0, LX_ZERO);
            7'd92: i = mk(OP_MOV, A_X0, A_PREF, A_PREF);
            7'd93: i = mk(OP_MOV, A_X1, A_QREF, A_QREF);
            7'd94: i = mk(OP_MOV, A_X2, A_T0, A_T0);
            7'd95: i = mk(OP_MOV, A_X3, A_T0, A_T0);
            7'd96: i = mk(OP_MOV, A_X4, A_T0, A_T0);
            7'd97:
            begin
                i = mk(OP_MOV, A_X5, A_T0, A_T0);
                i.to_tail = 1'b1;
            end
            default: i.last = 1'b1;
        endcase
        return i;
    endfunction

endpackage

### sv/vdq_stream_if.sv
// Handshake interfaces of the dq controller: request and result channels.
// Depends on vdq_pkg for the data width.
`timescale 1ns / 1ps
interface vdq_req_if import vdq_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     req_type;
    logic signed [DATA_W-1:0] volt_d;
    logic signed [DATA_W-1:0] volt_q;
    logic signed [DATA_W-1:0] curr_d;
    logic signed [DATA_W-1:0] curr_q;

    modport source (output valid, req_type, volt_d, volt_q, curr_d, curr_q, input ready);
    modport sink (input valid, req_type, volt_d, volt_q, curr_d, curr_q, output ready);
endinterface

interface vdq_rsp_if import vdq_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] drive_d;
    logic signed [DATA_W-1:0] drive_q;
    logic                     saturated;

    modport source (output valid, drive_d, drive_q, saturated, input ready);
    modport sink (input valid, drive_d, drive_q, saturated, output ready);
endinterface

### sv/vsi_dq_power_current_controller.sv
// Each microinstruction passes through fetch and execute; a multiply accumulates four 32x32
// partial products, then negates and writes back; a divide produces one quotient bit per
// cycle, 128 bits, then writes back.
// A new transaction is taken only in idle, after the last result went to the output register.
// Reset clears the sequencer, the output valid and all register-file valid bits,
// so configuration and state read as their reset values until written.
`timescale 1ns / 1ps
module vsi_dq_power_current_controller import vdq_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    vdq_req_if.sink              req,
    vdq_rsp_if.source            rsp,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_idx,
    input  logic [DATA_W-1:0]    cfg_data
);

    localparam logic [DATA_W-1:0] ONE_VAL = DATA_W'(1) << FRAC_BITS;
    localparam logic [6:0] SH_MUL  = 7'(FRAC_BITS);
    localparam logic [6:0] SH_MULH = 7'(FRAC_BITS + 1);

    state_t state_reg, state_next;
    logic [PC_W-1:0] pc_reg, pc_next;
    instr_t ins;

    logic [DATA_W-1:0] mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] vld_reg;
    logic [DATA_W-1:0] opa_reg, opb_reg;

    logic              in_type_reg;
    logic [DATA_W-1:0] in_vd_reg, in_vq_reg, in_id_reg, in_iq_reg;

    logic [DATA_W-1:0]  mag_a_reg, mag_b_reg;
    logic               neg_reg;
    logic [1:0]         mcnt_reg;
    logic [127:0]       acc_reg, prod_reg;

    logic [127:0]       dnum_reg, q_reg;
    logic [DATA_W:0]    rem_reg;
    logic [DATA_W-1:0]  dden_reg;
    logic               dneg_reg;
    logic [6:0]         dcnt_reg;

    logic              sat_reg;
    logic [DATA_W-1:0] res_d_reg, res_q_reg;
    logic              out_valid_reg;
    logic [DATA_W-1:0] out_d_reg, out_q_reg;
    logic              out_sat_reg;

    logic              wb_en, wb_clip, adv, done_go;
    logic [DATA_W-1:0] wb_data;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [DATA_W-1:0] mem_wdata, cfg_masked;

    logic [DATA_W-1:0] add_sum, sub_diff, add_res, sub_res, ldx_val, simple_res;
    logic              add_ovf, sub_ovf, simple_clip;
    logic [DATA_W-1:0] mag_a;
    logic [31:0]       a_half, b_half;
    logic [63:0]       pp;
    logic [1:0]        pp_pos;
    logic [127:0]      pp_sh;
    logic [6:0]        mul_shamt;
    logic [127:0]      mul_sh;
    logic              mul_clip;
    logic [DATA_W-1:0] mul_res;
    logic [DATA_W:0]   rem_sh, rem_nx;
    logic              rem_ge;
    logic [DATA_W-1:0] div_lim, div_res;
    logic              div_clip;

    assign ins = prog(pc_reg);

    // saturating add and subtract
    assign add_sum  = opa_reg + opb_reg;
    assign sub_diff = opa_reg - opb_reg;
    assign add_ovf  = (opa_reg[63] == opb_reg[63]) && (add_sum[63] != opa_reg[63]);
    assign sub_ovf  = (opa_reg[63] != opb_reg[63]) && (sub_diff[63] != opa_reg[63]);
    assign add_res  = add_ovf ? (opa_reg[63] ? S_MIN : S_MAX) : add_sum;
    assign sub_res  = sub_ovf ? (opa_reg[63] ? S_MIN : S_MAX) : sub_diff;

    always_comb
    begin
        case (ins.b)
            LX_VD:   ldx_val = in_vd_reg;
            LX_VQ:   ldx_val = in_vq_reg;
            LX_ID:   ldx_val = in_id_reg;
            LX_IQ:   ldx_val = in_iq_reg;
            LX_ONE:  ldx_val = ONE_VAL;
            default: ldx_val = '0;
        endcase
    end

    always_comb
    begin
        simple_res  = opa_reg;
        simple_clip = 1'b0;
        case (ins.op)
            OP_LDX: simple_res = ldx_val;
            OP_ADD:
            begin
                simple_res  = add_res;
                simple_clip = add_ovf;
            end
            OP_SUB:
            begin
                simple_res  = sub_res;
                simple_clip = sub_ovf;
            end
            default: simple_res = opa_reg;
        endcase
    end

    // multiplier: magnitudes, four partial products, sign, floor shift
    assign mag_a  = opa_reg[63] ? (~opa_reg + DATA_W'(1)) : opa_reg;
    assign a_half = mcnt_reg[1] ? mag_a_reg[63:32] : mag_a_reg[31:0];
    assign b_half = mcnt_reg[0] ? mag_b_reg[63:32] : mag_b_reg[31:0];
    assign pp     = 64'(a_half) * 64'(b_half);
    assign pp_pos = {1'b0, mcnt_reg[1]} + {1'b0, mcnt_reg[0]};

    always_comb
    begin
        case (pp_pos)
            2'd0:    pp_sh = {64'd0, pp};
            2'd1:    pp_sh = {32'd0, pp, 32'd0};
            default: pp_sh = {pp, 64'd0};
        endcase
    end

    assign mul_shamt = (ins.op == OP_MULH) ? SH_MULH : SH_MUL;
    assign mul_sh    = $unsigned($signed(prod_reg) >>> mul_shamt);
    assign mul_clip  = mul_sh[127:63] != {65{mul_sh[63]}};
    assign mul_res   = mul_clip ? (mul_sh[127] ? S_MIN : S_MAX) : mul_sh[63:0];

    // restoring divider, one quotient bit per cycle
    assign rem_sh   = {rem_reg[DATA_W-1:0], dnum_reg[127]};
    assign rem_ge   = rem_sh >= {1'b0, dden_reg};
    assign rem_nx   = rem_ge ? (rem_sh - {1'b0, dden_reg}) : rem_sh;
    assign div_lim  = dneg_reg ? S_MIN : S_MAX;
    assign div_clip = (q_reg[127:64] != '0) || (q_reg[63:0] > div_lim);
    assign div_res  = div_clip ? div_lim
                    : (dneg_reg ? (~q_reg[63:0] + DATA_W'(1)) : q_reg[63:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pc_reg    <= PC_STEP;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        wb_en      = 1'b0;
        wb_data    = simple_res;
        wb_clip    = 1'b0;
        adv        = 1'b0;
        done_go    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = S_FETCH;
                    pc_next    = req.req_type ? PC_STEP : PC_INIT;
                end
            end
            S_FETCH: state_next = S_EXEC;
            S_EXEC:
            begin
                case (ins.op) inside
                    OP_MUL, OP_MULH: state_next = S_MUL;
                    OP_DIV:          state_next = S_DIV;
                    default:
                    begin
                        wb_en   = 1'b1;
                        wb_data = simple_res;
                        wb_clip = simple_clip;
                        adv     = 1'b1;
                    end
                endcase
            end
            S_MUL:
            begin
                if (mcnt_reg == 2'd3)
                    state_next = S_MNEG;
            end
            S_MNEG: state_next = S_MFIN;
            S_MFIN:
            begin
                wb_en   = 1'b1;
                wb_data = mul_res;
                wb_clip = mul_clip;
                adv     = 1'b1;
            end
            S_DIV:
            begin
                if (dcnt_reg == '1)
                    state_next = S_DFIN;
            end
            S_DFIN:
            begin
                wb_en   = 1'b1;
                wb_data = div_res;
                wb_clip = div_clip;
                adv     = 1'b1;
            end
            S_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || rsp.ready)
                begin
                    done_go    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
        if (adv)
        begin
            if (ins.last)
                state_next = S_DONE;
            else
            begin
                state_next = S_FETCH;
                pc_next    = ins.to_tail ? PC_TAIL : (pc_reg + PC_W'(1));
            end
        end
    end

    // register file: configuration, previous inputs, states, temporaries
    always_comb
    begin
        unique case (cfg_idx)
            CFG_W:   cfg_masked = cfg_data & W_MASK;
            CFG_H:   cfg_masked = cfg_data & H_MASK;
            default: cfg_masked = cfg_data;
        endcase
    end

    assign mem_we    = wb_en || cfg_we;
    assign mem_waddr = wb_en ? ins.dst : ADDR_W'(cfg_idx);
    assign mem_wdata = wb_en ? wb_data : cfg_masked;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (state_reg == S_FETCH)
        begin
            opa_reg <= vld_reg[ins.a] ? mem[ins.a] : ((ins.a == A_H) ? H_RESET : '0);
            opb_reg <= vld_reg[ins.b] ? mem[ins.b] : ((ins.b == A_H) ? H_RESET : '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (mem_we)
            vld_reg[mem_waddr] <= 1'b1;
    end

    // input latch and arithmetic units
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            in_type_reg <= req.req_type;
            in_vd_reg   <= req.volt_d;
            in_vq_reg   <= req.volt_q;
            in_id_reg   <= req.curr_d;
            in_iq_reg   <= req.curr_q;
        end
        if (state_reg == S_EXEC)
        begin
            mag_a_reg <= mag_a;
            mag_b_reg <= opb_reg[63] ? (~opb_reg + DATA_W'(1)) : opb_reg;
            neg_reg   <= opa_reg[63] ^ opb_reg[63];
            acc_reg   <= '0;
            mcnt_reg  <= '0;
            dneg_reg  <= opa_reg[63];
            dnum_reg  <= {64'd0, mag_a} << FRAC_BITS;
            dden_reg  <= opb_reg;
            rem_reg   <= '0;
            q_reg     <= '0;
            dcnt_reg  <= '0;
        end
        if (state_reg == S_MUL)
        begin
            acc_reg  <= acc_reg + pp_sh;
            mcnt_reg <= mcnt_reg + 2'd1;
        end
        if (state_reg == S_MNEG)
            prod_reg <= neg_reg ? (~acc_reg + 128'd1) : acc_reg;
        if (state_reg == S_DIV)
        begin
            rem_reg  <= rem_nx;
            dnum_reg <= {dnum_reg[126:0], 1'b0};
            q_reg    <= {q_reg[126:0], rem_ge};
            dcnt_reg <= dcnt_reg + 7'd1;
        end
        if (wb_en && ins.osel == OSEL_D)
            res_d_reg <= wb_data;
        if (wb_en && ins.osel == OSEL_Q)
            res_q_reg <= wb_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sat_reg <= 1'b0;
        else if (req.valid && req.ready)
            sat_reg <= 1'b0;
        else if (wb_en && wb_clip)
            sat_reg <= 1'b1;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (done_go)
            out_valid_reg <= 1'b1;
        else if (rsp.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (done_go)
        begin
            out_d_reg   <= res_d_reg;
            out_q_reg   <= res_q_reg;
            out_sat_reg <= sat_reg;
        end
    end

    assign req.ready     = (state_reg == S_IDLE);
    assign rsp.valid     = out_valid_reg;
    assign rsp.drive_d   = out_d_reg;
    assign rsp.drive_q   = out_q_reg;
    assign rsp.saturated = out_sat_reg;

    `include "vsi_dq_power_current_controller_assert.svh"

    `VDQ_ASSERT_NXT(a_accept_starts, req.valid && req.ready,
        state_reg == S_FETCH && (pc_reg == PC_STEP || pc_reg == PC_INIT) &&
        sat_reg == 1'b0 && in_type_reg == (pc_reg == PC_STEP),
        "accepted transaction did not start its program")
    `VDQ_ASSERT_IMP(a_busy_not_ready, state_reg != S_IDLE, !req.ready,
        "ready raised while a transaction is in flight")
    `VDQ_ASSERT_IMP(a_div_den_pos, state_reg == S_DIV, dden_reg != '0 && !dden_reg[63],
        "divider running with a non-positive denominator")

endmodule

### dv/vsi_dq_power_current_controller_tb.sv
// Self-checking testbench of the dq power and current controller.
// Depends on vdq_pkg, the vdq_req_if/vdq_rsp_if interfaces and the top level.
`timescale 1ns / 1ps
module vsi_dq_power_current_controller_tb;
    import vdq_pkg::*;

    localparam int  FRAC       = FRAC_BITS_DEF;
    localparam int  HOLD_LEN   = 3000;
    localparam int  HOLD_AT    = 300;
    localparam longint LIMIT   = 6000000;
    localparam logic [CFG_IDX_W-1:0] R_PREF = 3'd0;
    localparam logic [CFG_IDX_W-1:0] R_QREF = 3'd1;
    localparam logic [CFG_IDX_W-1:0] R_KP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] R_KI   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] R_KPC  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] R_KIC  = 3'd5;
    localparam bit REQ_INIT = 1'b0;
    localparam bit REQ_STEP = 1'b1;
    localparam logic signed [63:0] ONE_Q = 64'sh0000_0001_0000_0000;

    typedef struct {
        bit                 kind;
        logic signed [63:0] vd, vq, id, iq;
    } ctrl_req_t;

    typedef struct {
        logic signed [63:0] drive_d, drive_q;
        logic               sat;
    } drive_t;

    logic clk = 1'b0;
    logic rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [DATA_W-1:0]    cfg_data;

    vdq_req_if req_ch ();
    vdq_rsp_if rsp_ch ();

    vsi_dq_power_current_controller uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req_ch.sink),
        .rsp      (rsp_ch.source),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data)
    );

    always #6 clk = ~clk;

    // controller copy: registers, states, last inputs
    logic signed [63:0] m_pref, m_qref, m_kp, m_ki, m_kpc, m_kic, m_w, m_h;
    logic signed [63:0] m_x [6];
    logic signed [63:0] m_prev [4];
    bit clip_seen;

    ctrl_req_t pend_reqs [$];
    drive_t    drive_exp [$];
    int  errors = 0;
    int  n_sent = 0;
    int  n_checked = 0;
    int  n_init = 0;
    int  n_sat = 0;
    int  n_phase = 0;
    longint cyc = 0;

    function automatic logic signed [63:0] sadd(input logic signed [63:0] a, b);
        logic signed [64:0] r;
        r = {a[63], a} + {b[63], b};
        if (r[64] != r[63])
        begin
            clip_seen = 1'b1;
            return r[64] ? S_MIN : S_MAX;
        end
        return r[63:0];
    endfunction

    function automatic logic signed [63:0] ssub(input logic signed [63:0] a, b);
        logic signed [64:0] r;
        r = {a[63], a} - {b[63], b};
        if (r[64] != r[63])
        begin
            clip_seen = 1'b1;
            return r[64] ? S_MIN : S_MAX;
        end
        return r[63:0];
    endfunction

    // exact product, floor shift, saturate
    function automatic logic signed [63:0] mulsh(input logic signed [63:0] a, b, input int s);
        logic signed [127:0] p;
        p = 128'(a) * 128'(b);
        p = p >>> s;
        if (p[127:63] != {65{p[127]}})
        begin
            clip_seen = 1'b1;
            return p[127] ? S_MIN : S_MAX;
        end
        return p[63:0];
    endfunction

    function automatic logic signed [63:0] fmul(input logic signed [63:0] a, b);
        return mulsh(a, b, FRAC);
    endfunction

    function automatic logic signed [63:0] halfh(input logic signed [63:0] v);
        return mulsh(m_h, v, FRAC + 1);
    endfunction

    // truncating quotient, divisor positive
    function automatic logic signed [63:0] sdiv(input logic signed [63:0] n, d);
        logic signed [127:0] nn;
        logic [127:0] num, q;
        bit neg;
        neg = n[63];
        nn = 128'(n);
        num = neg ? -nn : nn;
        num = num << FRAC;
        q = num / {64'd0, d};
        if (neg ? (q > 128'h8000_0000_0000_0000) : (q > 128'h7FFF_FFFF_FFFF_FFFF))
        begin
            clip_seen = 1'b1;
            return neg ? S_MIN : S_MAX;
        end
        return neg ? -q[63:0] : q[63:0];
    endfunction

    function automatic drive_t next_drive(input ctrl_req_t t);
        logic signed [63:0] s0, s1, s2, s3, s4, s5, bd, bq, den;
        logic signed [63:0] r0, r1, r2, r3, r4, r5, n0, n1, n2, n3;
        drive_t o;
        clip_seen = 1'b0;
        if (t.kind == REQ_INIT)
        begin
            m_x[0] = m_pref;
            m_x[1] = m_qref;
            for (int i = 2; i < 6; i++) m_x[i] = '0;
        end
        else
        begin
            s0 = sadd(m_pref, m_pref);
            s1 = sadd(m_qref, m_qref);
            s2 = sadd(t.vd, m_prev[0]);
            s3 = sadd(t.vq, m_prev[1]);
            s4 = sadd(t.id, m_prev[2]);
            s5 = sadd(t.iq, m_prev[3]);
            bd = fmul(m_w, t.id);
            bq = fmul(m_w, t.iq);
            den = sadd(ONE_Q, halfh(m_w));
            r0 = sadd(m_x[0], halfh(ssub(sadd(fmul(bd, s2), fmul(bq, s3)), fmul(m_w, m_x[0]))));
            r1 = sadd(m_x[1], halfh(ssub(ssub(fmul(bd, s3), fmul(bq, s2)), fmul(m_w, m_x[1]))));
            r2 = sadd(m_x[2], halfh(ssub(s0, m_x[0])));
            r3 = sadd(m_x[3], halfh(ssub(m_x[1], s1)));
            r4 = sadd(m_x[4], halfh(ssub(sadd(ssub(fmul(m_ki, m_x[2]), fmul(m_kp, m_x[0])),
                                              fmul(m_kp, s0)), s4)));
            r5 = sadd(m_x[5], halfh(ssub(ssub(sadd(fmul(m_kp, m_x[1]), fmul(m_ki, m_x[3])),
                                              fmul(m_kp, s1)), s5)));
            n0 = sdiv(r0, den);
            n1 = sdiv(r1, den);
            n2 = ssub(r2, halfh(n0));
            n3 = sadd(r3, halfh(n1));
            m_x[4] = sadd(r4, halfh(ssub(fmul(m_ki, n2), fmul(m_kp, n0))));
            m_x[5] = sadd(r5, halfh(sadd(fmul(m_kp, n1), fmul(m_ki, n3))));
            m_x[0] = n0;
            m_x[1] = n1;
            m_x[2] = n2;
            m_x[3] = n3;
        end
        m_prev[0] = t.vd;
        m_prev[1] = t.vq;
        m_prev[2] = t.id;
        m_prev[3] = t.iq;
        o.drive_d = sadd(fmul(m_kpc, ssub(sadd(fmul(m_kp, ssub(m_pref, m_x[0])),
                                               fmul(m_ki, m_x[2])), t.id)),
                         fmul(m_kic, m_x[4]));
        o.drive_q = sadd(fmul(m_kpc, ssub(sadd(fmul(m_kp, ssub(m_x[1], m_qref)),
                                               fmul(m_ki, m_x[3])), t.iq)),
                         fmul(m_kic, m_x[5]));
        o.sat = clip_seen;
        return o;
    endfunction

    // value of any magnitude, with the extremes now and then
    function automatic logic signed [63:0] rand_val();
        logic signed [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 19))
            0: return S_MIN;
            1: return S_MAX;
            2: return '0;
            3: return v;
            default: return v >>> $urandom_range(8, 40);
        endcase
    endfunction

    // cycle counter and watchdog
    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (cyc > LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cyc);
            $display("Test completed with failures");
            $finish;
        end
    end

    // request driver
    ctrl_req_t cur;
    int req_gap = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                drive_exp.insert(drive_exp.size(), next_drive(cur));
                n_sent++;
                if (cur.kind == REQ_INIT) n_init++;
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (req_gap > 0)
                begin
                    req_gap--;
                    req_ch.valid <= 1'b0;
                end
                else if (pend_reqs.size() > 0)
                begin
                    cur = pend_reqs.pop_front();
                    req_ch.valid    <= 1'b1;
                    req_ch.req_type <= cur.kind;
                    req_ch.volt_d   <= cur.vd;
                    req_ch.volt_q   <= cur.vq;
                    req_ch.curr_d   <= cur.id;
                    req_ch.curr_q   <= cur.iq;
                    req_gap = ((n_sent / 150) % 3 == 1) ? 0 : $urandom_range(0, 11);
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    // result monitor
    int rsp_gap = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    always @(posedge clk)
    begin
        drive_t e;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (drive_exp.size() == 0)
                begin
                    errors++;
                    $display("%0t: result with nothing expected: d=%h q=%h sat=%b", $time,
                             rsp_ch.drive_d, rsp_ch.drive_q, rsp_ch.saturated);
                end
                else
                begin
                    e = drive_exp.pop_front();
                    if (rsp_ch.drive_d !== e.drive_d)
                    begin
                        errors++;
                        $display("%0t: drive_d expected %h actual %h", $time,
                                 e.drive_d, rsp_ch.drive_d);
                    end
                    if (rsp_ch.drive_q !== e.drive_q)
                    begin
                        errors++;
                        $display("%0t: drive_q expected %h actual %h", $time,
                                 e.drive_q, rsp_ch.drive_q);
                    end
                    if (rsp_ch.saturated !== e.sat)
                    begin
                        errors++;
                        $display("%0t: saturated expected %b actual %b", $time,
                                 e.sat, rsp_ch.saturated);
                    end
                    if (e.sat) n_sat++;
                end
                n_checked++;
                rsp_gap = ((n_checked / 120) % 3 == 2) ? 0 : $urandom_range(0, 11);
                // hold off once for a long stretch while requests keep coming
                if (n_checked == HOLD_AT && !hold_done)
                begin
                    hold_done = 1'b1;
                    hold_left = HOLD_LEN;
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (rsp_gap > 0)
            begin
                rsp_gap--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        case (idx)
            R_PREF: m_pref = val;
            R_QREF: m_qref = val;
            R_KP:   m_kp   = val;
            R_KI:   m_ki   = val;
            R_KPC:  m_kpc  = val;
            R_KIC:  m_kic  = val;
            CFG_W:  m_w    = val & W_MASK;
            CFG_H:  m_h    = val & H_MASK;
            default: ;
        endcase
    endtask

    task automatic cfg_done();
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        do @(negedge clk);
        while (pend_reqs.size() != 0 || req_ch.valid || drive_exp.size() != 0);
        repeat (8) @(negedge clk);
    endtask

    task automatic push_req(input bit kind, input logic signed [63:0] vd, vq, id, iq);
        ctrl_req_t t;
        t.kind = kind;
        t.vd = vd;
        t.vq = vq;
        t.id = id;
        t.iq = iq;
        pend_reqs.insert(pend_reqs.size(), t);
    endtask

    function automatic logic [63:0] rand_gain();
        case ($urandom_range(0, 9))
            0: return S_MIN;
            1: return S_MAX;
            2: return '0;
            3: return {$urandom, $urandom};
            default: return $signed({$urandom, $urandom}) >>> $urandom_range(26, 40);
        endcase
    endfunction

    initial
    begin
        logic [63:0] hval, wval;
        int len;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_idx         = '0;
        cfg_data        = '0;
        req_ch.valid    = 1'b0;
        req_ch.req_type = REQ_INIT;
        req_ch.volt_d   = '0;
        req_ch.volt_q   = '0;
        req_ch.curr_d   = '0;
        req_ch.curr_q   = '0;
        rsp_ch.ready    = 1'b0;
        m_pref = '0; m_qref = '0; m_kp = '0; m_ki = '0;
        m_kpc = '0; m_kic = '0; m_w = '0; m_h = H_RESET;
        for (int i = 0; i < 6; i++) m_x[i] = '0;
        for (int i = 0; i < 4; i++) m_prev[i] = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: step with no init before it, then init and extremes
        push_req(REQ_STEP, 64'sd3 <<< 32, -(64'sd2 <<< 32), 64'sd1 <<< 32, 64'sd5 <<< 30);
        push_req(REQ_STEP, S_MAX, S_MIN, S_MAX, S_MIN);
        push_req(REQ_INIT, S_MIN, S_MAX, S_MIN, S_MAX);
        push_req(REQ_STEP, '0, '0, '0, '0);
        wait_idle();
        n_phase++;

        // moderate gains, init and steps, then steps with full-scale inputs
        cfg_write(R_PREF, 64'sd10 <<< 32);
        cfg_write(R_QREF, -(64'sd4 <<< 32));
        cfg_write(R_KP, 64'sd1 <<< 31);
        cfg_write(R_KI, 64'sd3 <<< 32);
        cfg_write(R_KPC, 64'sd2 <<< 32);
        cfg_write(R_KIC, 64'sd1 <<< 30);
        cfg_write(CFG_W, 64'd50 << 32);
        cfg_write(CFG_H, 64'd429497);
        cfg_done();
        push_req(REQ_INIT, 64'sd300 <<< 32, 64'sd0, 64'sd2 <<< 32, -(64'sd1 <<< 32));
        for (int i = 0; i < 4; i++)
            push_req(REQ_STEP, (64'sd300 + i) <<< 32, 64'sd1 <<< 28,
                     64'sd2 <<< 32, -(64'sd1 <<< 32));
        push_req(REQ_STEP, S_MAX, S_MAX, S_MAX, S_MAX);
        push_req(REQ_STEP, S_MIN, S_MIN, S_MIN, S_MIN);
        wait_idle();
        n_phase++;

        // zero step size: states hold
        cfg_write(CFG_H, 64'd0);
        cfg_done();
        push_req(REQ_STEP, 64'sd7 <<< 32, 64'sd1, 64'sd3 <<< 32, -64'sd9);
        push_req(REQ_STEP, -(64'sd7 <<< 32), -64'sd1, 64'sd0, 64'sd9);
        wait_idle();
        n_phase++;

        // largest cutoff, unit step: divisor near saturation, every gain and reference at an extreme
        cfg_write(CFG_W, {$urandom, $urandom} | W_MASK);
        cfg_write(CFG_H, 64'h1_0000_0000 | {$urandom, $urandom} & ~H_MASK);
        cfg_write(R_PREF, S_MAX);
        cfg_write(R_QREF, S_MIN);
        cfg_write(R_KP, S_MIN);
        cfg_write(R_KI, S_MAX);
        cfg_write(R_KPC, S_MAX);
        cfg_write(R_KIC, S_MIN);
        cfg_done();
        push_req(REQ_INIT, 64'sd1 <<< 32, 64'sd1 <<< 32, 64'sd1 <<< 32, 64'sd1 <<< 32);
        push_req(REQ_STEP, 64'sd1 <<< 32, -(64'sd1 <<< 32), 64'sd1, -64'sd1);
        push_req(REQ_STEP, S_MAX, S_MIN, S_MIN, S_MAX);
        push_req(REQ_STEP, -64'sd1, -64'sd1, -64'sd1, -64'sd1);
        wait_idle();
        n_phase++;

        // random phases: mostly init followed by a run of steps
        for (int ph = 0; ph < 9; ph++)
        begin
            wval = (ph == 2) ? W_MASK : (ph == 5) ? 64'd0 :
                   {$urandom, $urandom} >> $urandom_range(19, 63);
            case ($urandom_range(0, 5))
                0: hval = 64'h1_0000_0000;
                1: hval = 64'd1;
                2: hval = {$urandom_range(0, 1), $urandom};
                default: hval = 64'($urandom_range(1, 1 << 24));
            endcase
            cfg_write(R_PREF, rand_gain());
            cfg_write(R_QREF, rand_gain());
            cfg_write(R_KP, rand_gain());
            cfg_write(R_KI, rand_gain());
            cfg_write(R_KPC, rand_gain());
            cfg_write(R_KIC, rand_gain());
            cfg_write(CFG_W, wval);
            cfg_write(CFG_H, hval);
            cfg_done();
            while (pend_reqs.size() < 200)
            begin
                if ($urandom_range(0, 99) < 85)
                begin
                    len = $urandom_range(4, 30);
                    push_req(REQ_INIT, rand_val(), rand_val(), rand_val(), rand_val());
                    for (int k = 0; k < len; k++)
                        push_req(REQ_STEP, rand_val(), rand_val(), rand_val(), rand_val());
                end
                else
                    push_req(1'($urandom_range(0, 1)), {$urandom, $urandom},
                             {$urandom, $urandom}, {$urandom, $urandom},
                             {$urandom, $urandom});
            end
            wait_idle();
            n_phase++;
        end

        repeat (50) @(negedge clk);
        $display("Covered %0d phases of settings, %0d requests (%0d init), %0d results",
                 n_phase, n_sent, n_init, n_checked);
        $display("%0d results flagged saturation, %0d mismatches", n_sat, errors);
        if (errors == 0 && drive_exp.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
